// ===== design/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the C-style lexer
// Field widths, the result record and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  // payload widths
  localparam int CHAR_W  = 8;
  localparam int LINE_W  = 20;  // width of the line_number field
  localparam int CNT_W   = 16;  // token counter and token limit register
  localparam int KEPT_W  = 6;   // max_token_chars and kept length
  localparam int CFG_W   = 16;  // configuration write data

  // counter and line saturation widths
  localparam int TOKEN_COUNT_BITS = CNT_W;
  localparam int LINE_BITS        = 20;
  localparam int MAX_CHARS        = 63;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TOK_LIMIT       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKEN_CHARS = 1'b1;

  // result queue
  localparam int QDEPTH  = 4;
  localparam int PTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CHAR_W-1:0] token_char;
    logic              token_start;
    logic              token_end;
    logic [LINE_W-1:0] line_number;
    logic              overflow_error;
    logic              last_of_run;
  } clt_result_t;

endpackage : clt_pkg

`default_nettype wire

// ===== design/clt_if.sv =====
// ----------------------------------------------------------------------------
// clt_if: channel interfaces of the C-style lexer
// Source byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_in_if;
  import clt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface : clt_in_if

interface clt_out_if;
  import clt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] token_char;
  logic              token_start;
  logic              token_end;
  logic [LINE_W-1:0] line_number;
  logic              overflow_error;
  logic              last_of_run;

  modport source (output valid, output token_char, output token_start, output token_end,
                  output line_number, output overflow_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_char, input token_start, input token_end,
                  input line_number, input overflow_error, input last_of_run,
                  output ready);
endinterface : clt_out_if

interface clt_cfg_if;
  import clt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : clt_cfg_if

`default_nettype wire

// ===== design/clt_core.sv =====
// ----------------------------------------------------------------------------
// clt_core: lexer state and single-step token logic
// Holds the lexer state and configuration, and turns one registered source
// byte into up to two result records per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  clt_cfg_if.sink                     cfg_chan,
  input  wire logic                   step_en,
  input  wire logic [clt_pkg::CHAR_W-1:0] step_byte,
  input  wire logic                   step_eot,
  output logic [1:0]                  push_n,
  output clt_pkg::clt_result_t        res0,
  output clt_pkg::clt_result_t        res1
);
  import clt_pkg::*;

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_OP         = 3'd1;
  localparam logic [2:0] M_IDENT      = 3'd2;
  localparam logic [2:0] M_NUMBER     = 3'd3;
  localparam logic [2:0] M_LINE       = 3'd4;
  localparam logic [2:0] M_BLOCK      = 3'd5;
  localparam logic [2:0] M_BLOCK_STAR = 3'd6;

  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

  localparam logic [TOKEN_COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [LINE_BITS-1:0]        LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0]        LINE_ONE = LINE_BITS'(1);

  function automatic logic is_alpha(input logic [CHAR_W-1:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_op_lead(input logic [CHAR_W-1:0] b);
    return b == CH_SLASH || b == CH_AMP || b == CH_BAR || b == CH_EQ || b == CH_BANG ||
           b == CH_LT || b == CH_GT;
  endfunction

  function automatic logic pairs(input logic [CHAR_W-1:0] h, input logic [CHAR_W-1:0] b);
    logic p;
    p = 1'b0;
    if (h == CH_AMP) p = (b == CH_AMP);
    else if (h == CH_BAR) p = (b == CH_BAR);
    else if (h == CH_EQ || h == CH_BANG || h == CH_LT || h == CH_GT) p = (b == CH_EQ);
    return p;
  endfunction

  // configuration
  logic [CNT_W-1:0]  max_tok_r;
  logic [KEPT_W-1:0] max_chars_r;

  // lexer state
  logic [2:0]            mode_r, mode_nxt;
  logic [CHAR_W-1:0]     held_r, held_nxt;
  logic                  held_vld_r, held_vld_nxt;
  logic                  held_st_r, held_st_nxt;
  logic [KEPT_W-1:0]     kept_r, kept_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic                  halted_r, halted_nxt;

  logic [KEPT_W-1:0] lim;
  logic              lim_ge2;

  // two emit slots, A before B
  logic              a_v, a_st, a_en, b_v, b_st, b_en;
  logic [CHAR_W-1:0] a_ch, b_ch;
  logic              do_flush, do_take, do_ext, inc_line, set_line;

  logic              a_put, b_put, a_err, b_err, halt_a;
  logic [CNT_W-1:0]  cnt_a;
  clt_result_t       rec_a, rec_b;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    lim = max_chars_r;
    if (lim == '0) lim = KEPT_W'(1);
    if (int'(lim) > MAX_CHARS) lim = KEPT_W'(MAX_CHARS);
    lim_ge2 = lim >= KEPT_W'(2);
  end

  // step decode
  always_comb begin
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    held_st_nxt  = held_st_r;
    kept_nxt     = kept_r;
    a_v = 1'b0; a_ch = '0; a_st = 1'b0; a_en = 1'b0;
    b_v = 1'b0; b_ch = '0; b_st = 1'b0; b_en = 1'b0;
    do_flush = 1'b0;
    do_take  = 1'b0;
    do_ext   = 1'b0;
    inc_line = 1'b0;
    set_line = 1'b0;

    if (step_en && !halted_r) begin
      if (step_eot || step_byte == '0) begin
        do_flush = 1'b1;
        set_line = 1'b1;
      end else begin
        unique case (mode_r)
          M_OP: begin
            if (held_r == CH_SLASH && step_byte == CH_SLASH) begin
              held_vld_nxt = 1'b0; held_st_nxt = 1'b0; held_nxt = '0; kept_nxt = '0;
              mode_nxt = M_LINE;
            end else if (held_r == CH_SLASH && step_byte == CH_STAR) begin
              held_vld_nxt = 1'b0; held_st_nxt = 1'b0; held_nxt = '0; kept_nxt = '0;
              mode_nxt = M_BLOCK;
            end else if (pairs(held_r, step_byte)) begin
              held_vld_nxt = 1'b0; held_st_nxt = 1'b0; held_nxt = '0; kept_nxt = '0;
              mode_nxt = M_IDLE;
              a_v = 1'b1; a_ch = held_r; a_st = 1'b1; a_en = !lim_ge2;
              b_v = lim_ge2; b_ch = step_byte; b_st = 1'b0; b_en = 1'b1;
            end else begin
              do_flush = 1'b1;
              do_take  = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(step_byte) || is_digit(step_byte)) do_ext = 1'b1;
            else begin
              do_flush = 1'b1;
              do_take  = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(step_byte) || step_byte == CH_DOT) do_ext = 1'b1;
            else begin
              do_flush = 1'b1;
              do_take  = 1'b1;
            end
          end
          M_LINE: begin
            if (step_byte == CH_NL) begin
              inc_line = 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_BLOCK: begin
            if (step_byte == CH_STAR) mode_nxt = M_BLOCK_STAR;
            else if (step_byte == CH_NL) inc_line = 1'b1;
          end
          M_BLOCK_STAR: begin
            if (step_byte == CH_SLASH) mode_nxt = M_IDLE;
            else if (step_byte != CH_STAR) begin
              inc_line = (step_byte == CH_NL);
              mode_nxt = M_BLOCK;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            do_take  = 1'b1;
          end
        endcase
      end

      if (do_ext && kept_r < lim) begin
        a_v = 1'b1; a_ch = held_r; a_st = held_st_r; a_en = 1'b0;
        held_nxt    = step_byte;
        held_st_nxt = 1'b0;
        kept_nxt    = kept_r + KEPT_W'(1);
      end

      if (do_flush) begin
        a_v = held_vld_r; a_ch = held_r; a_st = held_st_r; a_en = 1'b1;
        held_vld_nxt = 1'b0; held_st_nxt = 1'b0; held_nxt = '0; kept_nxt = '0;
        mode_nxt = M_IDLE;
      end

      // a fresh byte handled as in idle mode, also the byte that ends a token
      if (do_take) begin
        if (step_byte == CH_NL) inc_line = 1'b1;
        else if (is_space(step_byte)) begin
        end else if (is_alpha(step_byte) || is_digit(step_byte) || is_op_lead(step_byte)) begin
          held_nxt = step_byte; held_vld_nxt = 1'b1; held_st_nxt = 1'b1;
          kept_nxt = KEPT_W'(1);
          if (is_alpha(step_byte)) mode_nxt = M_IDENT;
          else if (is_digit(step_byte)) mode_nxt = M_NUMBER;
          else mode_nxt = M_OP;
        end else begin
          b_v = 1'b1; b_ch = step_byte; b_st = 1'b1; b_en = 1'b1;
        end
      end
    end
  end

  // emit slots: token limit check and counting, A then B
  always_comb begin
    a_put  = a_v;
    a_err  = a_v && a_st && (cnt_r >= max_tok_r);
    halt_a = halted_r || a_err;
    cnt_a  = cnt_r;
    if (a_v && !a_err && a_st && cnt_r != CNT_MAX) cnt_a = cnt_r + CNT_W'(1);

    b_put   = b_v && !halt_a;
    b_err   = b_put && b_st && (cnt_a >= max_tok_r);
    cnt_nxt = cnt_a;
    if (b_put && !b_err && b_st && cnt_a != CNT_MAX) cnt_nxt = cnt_a + CNT_W'(1);
    halted_nxt = halt_a || b_err;

    rec_a.token_char     = a_err ? '0 : a_ch;
    rec_a.token_start    = a_st && !a_err;
    rec_a.token_end      = a_en && !a_err;
    rec_a.line_number    = line_r[LINE_W-1:0];
    rec_a.overflow_error = a_err;
    rec_a.last_of_run    = !b_put;

    rec_b.token_char     = b_err ? '0 : b_ch;
    rec_b.token_start    = b_st && !b_err;
    rec_b.token_end      = b_en && !b_err;
    rec_b.line_number    = line_r[LINE_W-1:0];
    rec_b.overflow_error = b_err;
    rec_b.last_of_run    = 1'b1;

    push_n = {1'b0, a_put} + {1'b0, b_put};
    res0   = a_put ? rec_a : rec_b;
    res1   = rec_b;
  end

  always_comb begin
    line_nxt = line_r;
    if (set_line) line_nxt = LINE_ONE;
    else if (inc_line && line_r != LINE_MAX) line_nxt = line_r + LINE_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tok_r   <= CNT_W'(65535);
      max_chars_r <= KEPT_W'(63);
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_TOK_LIMIT:       max_tok_r   <= cfg_chan.data[CNT_W-1:0];
        REG_MAX_TOKEN_CHARS: max_chars_r <= cfg_chan.data[KEPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      held_st_r  <= 1'b0;
      kept_r     <= '0;
      cnt_r      <= '0;
      line_r     <= LINE_ONE;
      halted_r   <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      held_st_r  <= held_st_nxt;
      kept_r     <= kept_nxt;
      cnt_r      <= cnt_nxt;
      line_r     <= line_nxt;
      halted_r   <= halted_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt flag cleared without reset");

  a_no_push_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> push_n == 2'd0) else $error("result produced while halted");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0) else $error("line counter reached zero");

endmodule : clt_core

`default_nettype wire

// ===== design/clt_outq.sv =====
// ----------------------------------------------------------------------------
// clt_outq: result queue of the C-style lexer
// Small register queue taking up to two results per cycle and handing one
// per transaction to the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           push_n,
  input  wire clt_pkg::clt_result_t push_d0,
  input  wire clt_pkg::clt_result_t push_d1,
  output logic                      space2,
  clt_out_if.source                 out_chan
);
  import clt_pkg::*;

  clt_result_t       mem [QDEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r, wr1;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  clt_result_t       head;

  assign wr1    = wr_r + PTR_W'(1);
  assign pop    = out_chan.valid && out_chan.ready;
  assign space2 = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign cnt_nxt = cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  assign head   = mem[rd_r];

  assign out_chan.valid          = cnt_r != '0;
  assign out_chan.token_char     = head.token_char;
  assign out_chan.token_start    = head.token_start;
  assign out_chan.token_end      = head.token_end;
  assign out_chan.line_number    = head.line_number;
  assign out_chan.overflow_error = head.overflow_error;
  assign out_chan.last_of_run    = head.last_of_run;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_r] <= push_d0;
    if (push_n == 2'd2) mem[wr1]  <= push_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push_n);
      if (pop) rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("result queue overfilled");

endmodule : clt_outq

`default_nettype wire

// ===== design/c_like_lexer_tokenizer.sv =====
// Flow: a byte is registered on acceptance, stepped through the lexer once
// the result queue has room for two results, and its results are offered on the
// output from the result queue. Throughput: one byte per cycle while the queue has
// room for two; a byte that yields two results (a paired operator, or a flush plus
// a one-character token) is buffered by a four-entry result queue.
// Reset (synchronous, rst_n low) restores configuration defaults and lexer state.
// ----------------------------------------------------------------------------
// c_like_lexer_tokenizer: streaming C-style lexer
// Byte input register, lexer step core and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module c_like_lexer_tokenizer (
  input  wire logic clk,
  input  wire logic rst_n,
  clt_in_if.sink    in_chan,
  clt_out_if.source out_chan,
  clt_cfg_if.sink   cfg_chan
);
  import clt_pkg::*;

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_byte_r;
  logic              in_eot_r;
  logic              adv;
  logic              space2;
  logic [1:0]        push_n;
  clt_result_t       res0, res1;

  // step the held byte only when the queue can take two results
  assign adv           = in_vld_r && space2;
  assign in_chan.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.text_byte;
      in_eot_r  <= in_chan.end_of_text;
    end
  end

  clt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .step_en   (adv),
    .step_byte (in_byte_r),
    .step_eot  (in_eot_r),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1)
  );

  clt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_d0  (res0),
    .push_d1  (res1),
    .space2   (space2),
    .out_chan (out_chan)
  );

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_byte_r) && $stable(in_eot_r))
    else $error("stalled input byte lost or changed");

endmodule : c_like_lexer_tokenizer

`default_nettype wire
